// ===== src/lrdc_pkg.sv =====
// Package for the log record deframer and checker: types, constants and the CRC step.
`timescale 1ns / 1ps
package lrdc_pkg;

	localparam int PAYLOAD_COUNT_BITS = 32;
	localparam int POS_W              = 48;
	localparam int QPTR_W             = 2;
	localparam int QDEPTH             = 1 << QPTR_W;
	localparam int QCNT_W             = QPTR_W + 1;
	localparam int ADDR_W             = 5;
	localparam int DATA_W             = 64;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [1:0] REG_MAGIC   = 2'd0;
	localparam logic [1:0] REG_MAX_LEN = 2'd1;
	localparam logic [1:0] REG_START   = 2'd2;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_OK   = 2'd1,
		KIND_EOF  = 2'd2,
		KIND_BAD  = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		PH_MAGIC   = 5'b00001,
		PH_OFFSET  = 5'b00010,
		PH_LENGTH  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CRC     = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [31:0]      magic;
		logic [31:0]      max_len;
		logic [POS_W-1:0] start_pos;
	} cfg_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       pbyte;
		logic [POS_W-1:0] pos;
	} res_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// ===== src/lrdc_front.sv =====
// Front end: takes stream words, tracks record fields and CRC, classifies results.
`timescale 1ns / 1ps
module lrdc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lrdc_pkg::cfg_t       cfg,
	input  logic                 pos_load,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [7:0]           data_byte,
	input  logic [62:0]          next_offset,
	output logic                 push,
	output lrdc_pkg::res_t       push_data,
	input  logic                 q_full
);
	import lrdc_pkg::*;

	phase_t                        phase_q, phase_d;
	logic [3:0]                    cnt_q, cnt_d;
	logic [31:0]                   magic_q, magic_d;
	logic [63:0]                   offs_q, offs_d;
	logic [62:0]                   exp_q, exp_d;
	logic [63:0]                   len_q, len_d;
	logic [PAYLOAD_COUNT_BITS-1:0] rem_q, rem_d;
	logic [31:0]                   crc_q, crc_d;
	logic [31:0]                   crcr_q, crcr_d;
	logic [POS_W-1:0]              pos_q, pos_d;
	logic                          halt_q, halt_d;
	logic                          fire;
	logic [31:0]                   crc_next;

	assign in_stall = q_full;
	assign fire     = in_valid & ~in_stall;
	assign crc_next = crc_byte(crc_q, data_byte);

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		magic_d   = magic_q;
		offs_d    = offs_q;
		exp_d     = exp_q;
		len_d     = len_q;
		rem_d     = rem_q;
		crc_d     = crc_q;
		crcr_d    = crcr_q;
		pos_d     = pos_q;
		halt_d    = halt_q;
		push      = 1'b0;
		push_data = '{kind: KIND_BYTE, pbyte: 8'd0, pos: '0};
		if (func) begin
			if (!halt_q) begin
				push           = 1'b1;
				push_data.kind = (phase_q == PH_MAGIC && cnt_q == 4'd0) ? KIND_EOF : KIND_BAD;
			end
			halt_d  = 1'b0;
			phase_d = PH_MAGIC;
			cnt_d   = 4'd0;
			magic_d = '0;
			offs_d  = '0;
			len_d   = '0;
			rem_d   = '0;
			crc_d   = CRC_INIT;
			crcr_d  = '0;
			pos_d   = cfg.start_pos;
		end else begin
			pos_d = pos_q + POS_W'(1);
			if (!halt_q) begin
				cnt_d = cnt_q + 4'd1;
				unique case (phase_q)
					PH_MAGIC: begin
						if (cnt_q == 4'd0) exp_d = next_offset;
						magic_d = {data_byte, magic_q[31:8]};
						if (cnt_q == 4'd3) begin
							cnt_d = 4'd0;
							if (magic_d != cfg.magic) push = 1'b1;
							else phase_d = PH_OFFSET;
						end
					end
					PH_OFFSET: begin
						offs_d = {data_byte, offs_q[63:8]};
						crc_d  = crc_next;
						if (cnt_q == 4'd7) begin
							cnt_d = 4'd0;
							if (offs_d != {1'b0, exp_q}) push = 1'b1;
							else phase_d = PH_LENGTH;
						end
					end
					PH_LENGTH: begin
						len_d = {data_byte, len_q[63:8]};
						crc_d = crc_next;
						if (cnt_q == 4'd7) begin
							cnt_d = 4'd0;
							if (len_d > {32'd0, cfg.max_len} ||
								(len_d >> PAYLOAD_COUNT_BITS) != 64'd0) begin
								push = 1'b1;
							end else begin
								rem_d   = len_d[PAYLOAD_COUNT_BITS-1:0];
								phase_d = (len_d == 64'd0) ? PH_CRC : PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						cnt_d           = cnt_q;
						crc_d           = crc_next;
						rem_d           = rem_q - PAYLOAD_COUNT_BITS'(1);
						if (rem_q == PAYLOAD_COUNT_BITS'(1)) phase_d = PH_CRC;
						push            = 1'b1;
						push_data.pbyte = data_byte;
					end
					PH_CRC: begin
						crcr_d = {data_byte, crcr_q[31:8]};
						if (cnt_q == 4'd3) begin
							push = 1'b1;
							if ((crc_q ^ CRC_INIT) == crcr_d) begin
								push_data.kind = KIND_OK;
								push_data.pos  = pos_d;
							end
						end
					end
					default: ;
				endcase
				// any push outside payload and ok is a failure
				if (push && push_data.kind == KIND_BYTE && phase_q != PH_PAYLOAD) begin
					push_data.kind = KIND_BAD;
					halt_d         = 1'b1;
				end
				if (push && push_data.kind != KIND_BYTE) begin
					phase_d = PH_MAGIC;
					cnt_d   = 4'd0;
					magic_d = '0;
					offs_d  = '0;
					len_d   = '0;
					rem_d   = '0;
					crc_d   = CRC_INIT;
					crcr_d  = '0;
				end
			end
		end
		push = push & fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			cnt_q   <= 4'd0;
			magic_q <= '0;
			offs_q  <= '0;
			exp_q   <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			crc_q   <= CRC_INIT;
			crcr_q  <= '0;
			pos_q   <= '0;
			halt_q  <= 1'b0;
		end else if (pos_load) begin
			pos_q <= cfg.start_pos;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			magic_q <= magic_d;
			offs_q  <= offs_d;
			exp_q   <= exp_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			crc_q   <= crc_d;
			crcr_q  <= crcr_d;
			pos_q   <= pos_d;
			halt_q  <= halt_d;
		end
	end

endmodule

// ===== src/lrdc_queue.sv =====
// Short result queue between front end and output stage.
`timescale 1ns / 1ps
module lrdc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lrdc_pkg::res_t push_data,
	output logic           full,
	input  logic           pop,
	output lrdc_pkg::res_t pop_data,
	output logic           nonempty
);
	import lrdc_pkg::*;

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_pop   = pop & nonempty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (do_pop) rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

endmodule

// ===== src/lrdc_back.sv =====
// Output stage: registered result word with valid/stall handshake.
`timescale 1ns / 1ps
module lrdc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_nonempty,
	input  lrdc_pkg::res_t                q_data,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    result_kind,
	output logic [7:0]                    payload_byte,
	output logic [lrdc_pkg::POS_W-1:0]    end_position
);
	import lrdc_pkg::*;

	logic out_valid_q;
	res_t out_q;

	assign q_pop        = q_nonempty & (~out_valid_q | ~out_stall);
	assign out_valid    = out_valid_q;
	assign result_kind  = out_q.kind;
	assign payload_byte = out_q.pbyte;
	assign end_position = out_q.pos;

	always_ff @(posedge clk) begin
		if (q_pop) out_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/log_record_deframer_checker_top.sv =====
// Top level of the log record deframer and checker: register port and channel wiring.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+----------------------------------------
//  in      | sink      | in_valid / in_stall | func, data_byte, next_offset
//  out     | source    | out_valid/out_stall | result_kind, payload_byte, end_position
//  cfg     | sink      | APB write           | record_magic, max_payload_length, start
//
// One input word per cycle while in_stall is low; the front end does the field checks and CRC step combinationally.
// A result passes through the result queue, then the output register, before it reaches out_valid.
// in_stall rises only when the four-entry result queue is full.
// Reset clears record state; byte position starts at zero.
`timescale 1ns / 1ps
module log_record_deframer_checker_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lrdc_pkg::ADDR_W-1:0]         paddr,
	input  logic [lrdc_pkg::DATA_W-1:0]         pwdata,
	output logic [lrdc_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [7:0]                          data_byte,
	input  logic [62:0]                         next_offset,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          result_kind,
	output logic [7:0]                          payload_byte,
	output logic [lrdc_pkg::POS_W-1:0]          end_position
);
	import lrdc_pkg::*;

	cfg_t       cfg_q;
	cfg_t       cfg_live;
	logic       wr_en;
	logic [1:0] reg_idx;
	logic       pos_load;
	logic       push, q_full, q_pop, q_nonempty;
	res_t       push_data, q_data;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[ADDR_W-1:3];
	assign wr_en    = psel & penable & pwrite & pready;
	assign pos_load = wr_en & (reg_idx == REG_START);

	assign cfg_live.magic     = cfg_q.magic;
	assign cfg_live.max_len   = cfg_q.max_len;
	assign cfg_live.start_pos = pos_load ? pwdata[POS_W-1:0] : cfg_q.start_pos;

	always_comb begin
		unique case (reg_idx)
			REG_MAGIC:   prdata = {32'd0, cfg_q.magic};
			REG_MAX_LEN: prdata = {32'd0, cfg_q.max_len};
			REG_START:   prdata = {{(DATA_W-POS_W){1'b0}}, cfg_q.start_pos};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic     <= '0;
			cfg_q.max_len   <= 32'hFFFF_FFFF;
			cfg_q.start_pos <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAGIC:   cfg_q.magic     <= pwdata[31:0];
				REG_MAX_LEN: cfg_q.max_len   <= pwdata[31:0];
				REG_START:   cfg_q.start_pos <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	lrdc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_live),
		.pos_load        (pos_load),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.data_byte       (data_byte),
		.next_offset     (next_offset),
		.push            (push),
		.push_data       (push_data),
		.q_full          (q_full)
	);

	lrdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.nonempty  (q_nonempty)
	);

	lrdc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.end_position (end_position)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the log record deframer and checker: directed records, then random streams.
`timescale 1ns / 1ps
module tb_top;
	import lrdc_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          PHASE_WORDS  = 64;
	localparam logic [1:0]  REG_NONE     = 2'd3;
	localparam logic [63:0] LEN_CAP      = {64{1'b1}} >> (64 - PAYLOAD_COUNT_BITS);

	typedef enum logic [1:0] {OP_EOF, OP_REC, OP_NOISE} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] magic;
		logic [63:0] off;
		logic [62:0] exp_off;
		logic [63:0] len;
		logic [7:0]  npay;
		logic        bad_crc;
		logic [7:0]  cut;
		logic        pin;
		res_t        verdict;
	} rec_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                func = 1'b0;
	logic [7:0]          data_byte = '0;
	logic [62:0]         next_offset = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          result_kind;
	logic [7:0]          payload_byte;
	logic [POS_W-1:0]    end_position;

	log_record_deframer_checker_top uut (.*);

	always #4 clk = ~clk;

	// predictor state
	logic [31:0]                   cfg_magic;
	logic [31:0]                   cfg_max_len;
	logic [POS_W-1:0]              cfg_start;
	phase_t                        fld;
	logic [3:0]                    fld_cnt;
	logic [31:0]                   magic_sr;
	logic [63:0]                   off_sr;
	logic [63:0]                   off_latched;
	logic [63:0]                   len_sr;
	logic [PAYLOAD_COUNT_BITS-1:0] pay_left;
	logic [31:0]                   crc_acc;
	logic [31:0]                   crc_rx;
	logic [POS_W-1:0]              pos_now;
	logic                          halted_now;

	res_t        results_due [$];
	int          n_fail = 0;
	int          live_words = 0;
	int unsigned cycles_run = 0;
	bit          tx_idle_on = 1'b0;
	bit          rx_idle_on = 1'b0;
	bit          hold_go = 1'b0;
	logic        hold_active = 1'b0;
	int          rx_burst = 0;
	cfg_t        phase_cfg [5];

	rec_t directed_plan [16] = '{
		'{OP_EOF, 32'h0, 64'h0, 63'h0, 64'h0, 8'd0, 1'b0, 8'd0, 1'b1, '{KIND_EOF, 8'h0, 48'd0}},
		'{OP_REC, 32'h0, 64'h0, 63'h0, 64'h0, 8'd0, 1'b0, 8'd0, 1'b1, '{KIND_OK, 8'h0, 48'd24}},
		'{OP_REC, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 64'd2, 8'd2,
			1'b0, 8'd0, 1'b1, '{KIND_OK, 8'h0, 48'd50}},
		'{OP_EOF, 32'h0, 64'h0, 63'h0, 64'h0, 8'd0, 1'b0, 8'd0, 1'b1, '{KIND_EOF, 8'h0, 48'd0}},
		'{OP_REC, 32'hFFFF_FFFF, 64'h0, 63'h0, 64'h0, 8'd0, 1'b0, 8'd0, 1'b1,
			'{KIND_BAD, 8'h0, 48'd0}},
		'{OP_EOF, 32'h0, 64'h0, 63'h0, 64'h0, 8'd0, 1'b0, 8'd0, 1'b0, '{KIND_EOF, 8'h0, 48'd0}},
		'{OP_REC, 32'h0, 64'h8000_0000_0000_0000, 63'h0, 64'h0, 8'd0, 1'b0, 8'd0, 1'b1,
			'{KIND_BAD, 8'h0, 48'd0}},
		'{OP_EOF, 32'h0, 64'h0, 63'h0, 64'h0, 8'd0, 1'b0, 8'd0, 1'b0, '{KIND_EOF, 8'h0, 48'd0}},
		'{OP_REC, 32'h0, 64'd5, 63'd5, 64'hFFFF_FFFF_0000_0000, 8'd0, 1'b0, 8'd0, 1'b1,
			'{KIND_BAD, 8'h0, 48'd0}},
		'{OP_EOF, 32'h0, 64'h0, 63'h0, 64'h0, 8'd0, 1'b0, 8'd0, 1'b0, '{KIND_EOF, 8'h0, 48'd0}},
		'{OP_REC, 32'h0, 64'd9, 63'd9, 64'd1, 8'd1, 1'b1, 8'd0, 1'b1, '{KIND_BAD, 8'h0, 48'd0}},
		'{OP_NOISE, 32'h0, 64'h0, 63'h0, 64'h0, 8'd2, 1'b0, 8'd0, 1'b0, '{KIND_EOF, 8'h0, 48'd0}},
		'{OP_EOF, 32'h0, 64'h0, 63'h0, 64'h0, 8'd0, 1'b0, 8'd0, 1'b0, '{KIND_EOF, 8'h0, 48'd0}},
		'{OP_REC, 32'h0, 64'd3, 63'd3, 64'd3, 8'd3, 1'b0, 8'd14, 1'b1, '{KIND_BAD, 8'h0, 48'd0}},
		'{OP_REC, 32'h0, 64'h0, 63'h0, 64'h0, 8'd0, 1'b0, 8'd0, 1'b1, '{KIND_OK, 8'h0, 48'd24}},
		'{OP_EOF, 32'h0, 64'h0, 63'h0, 64'h0, 8'd0, 1'b0, 8'd0, 1'b1, '{KIND_EOF, 8'h0, 48'd0}}
	};

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// reflected CRC-32, one data bit folded in per shift
	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c;
		for (int k = 0; k < 8; k++) begin
			x = (x >> 1) ^ ((x[0] ^ b[k]) ? 32'hEDB8_8320 : 32'h0);
		end
		return x;
	endfunction

	task automatic rearm_record();
		fld = PH_MAGIC;
		fld_cnt = '0;
		magic_sr = '0;
		off_sr = '0;
		len_sr = '0;
		pay_left = '0;
		crc_acc = '1;
		crc_rx = '0;
	endtask

	task automatic mark_invalid(output logic got, output res_t r);
		halted_now = 1'b1;
		rearm_record();
		got = 1'b1;
		r = '0;
		r.kind = KIND_BAD;
	endtask

	task automatic deframe_word(input logic f, input logic [7:0] b, input logic [62:0] eo,
			output logic got, output res_t r);
		got = 1'b0;
		r = '0;
		if (f) begin
			if (!halted_now) begin
				got = 1'b1;
				r.kind = (fld == PH_MAGIC && fld_cnt == 0) ? KIND_EOF : KIND_BAD;
			end
			halted_now = 1'b0;
			rearm_record();
			pos_now = cfg_start;
		end else begin
			pos_now = pos_now + POS_W'(1);
			if (!halted_now) begin
				case (fld)
				PH_MAGIC: begin
					if (fld_cnt == 0) off_latched = {1'b0, eo};
					magic_sr = {b, magic_sr[31:8]};
					fld_cnt++;
					if (fld_cnt == 4) begin
						if (magic_sr != cfg_magic) mark_invalid(got, r);
						else begin
							fld = PH_OFFSET;
							fld_cnt = '0;
						end
					end
				end
				PH_OFFSET: begin
					off_sr = {b, off_sr[63:8]};
					crc_acc = crc_step(crc_acc, b);
					fld_cnt++;
					if (fld_cnt == 8) begin
						if (off_sr != off_latched) mark_invalid(got, r);
						else begin
							fld = PH_LENGTH;
							fld_cnt = '0;
						end
					end
				end
				PH_LENGTH: begin
					len_sr = {b, len_sr[63:8]};
					crc_acc = crc_step(crc_acc, b);
					fld_cnt++;
					if (fld_cnt == 8) begin
						if (len_sr > {32'd0, cfg_max_len} || len_sr > LEN_CAP) begin
							mark_invalid(got, r);
						end else begin
							pay_left = len_sr[PAYLOAD_COUNT_BITS-1:0];
							fld = (len_sr == 0) ? PH_CRC : PH_PAYLOAD;
							fld_cnt = '0;
						end
					end
				end
				PH_PAYLOAD: begin
					crc_acc = crc_step(crc_acc, b);
					pay_left--;
					if (pay_left == 0) fld = PH_CRC;
					got = 1'b1;
					r.kind = KIND_BYTE;
					r.pbyte = b;
				end
				default: begin
					crc_rx = {b, crc_rx[31:8]};
					fld_cnt++;
					if (fld_cnt == 4) begin
						if (~crc_acc != crc_rx) mark_invalid(got, r);
						else begin
							rearm_record();
							got = 1'b1;
							r.kind = KIND_OK;
							r.pos = pos_now;
						end
					end
				end
				endcase
			end
		end
	endtask

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic offer(input logic f, input logic [7:0] b, input logic [62:0] eo,
			input logic pin, input res_t pinned);
		logic got;
		res_t r;
		logic live;
		live = !halted_now || f;
		if (tx_idle_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		data_byte <= b;
		next_offset <= eo;
		do @(posedge clk); while (in_stall);
		deframe_word(f, b, eo, got, r);
		if (got) begin
			if (pin && r.kind != KIND_BYTE) results_due.push_back(pinned);
			else results_due.push_back(r);
		end
		if (live) live_words++;
		@(negedge clk);
	endtask

	task automatic send_record(input rec_t rq);
		logic [7:0] bytes_out [$];
		logic [31:0] sum;
		int n;
		case (rq.op)
		OP_EOF: offer(1'b1, 8'($urandom), 63'(rnd64()), rq.pin, rq.verdict);
		OP_NOISE: begin
			for (int i = 0; i < rq.npay; i++) offer(1'b0, 8'($urandom), 63'(rnd64()), 1'b0, '0);
		end
		default: begin
			for (int i = 0; i < 4; i++) bytes_out.push_back(rq.magic[8*i +: 8]);
			for (int i = 0; i < 8; i++) bytes_out.push_back(rq.off[8*i +: 8]);
			for (int i = 0; i < 8; i++) bytes_out.push_back(rq.len[8*i +: 8]);
			for (int i = 0; i < rq.npay; i++) bytes_out.push_back(8'($urandom));
			sum = '1;
			for (int i = 4; i < bytes_out.size(); i++) sum = crc_step(sum, bytes_out[i]);
			sum = ~sum;
			if (rq.bad_crc) sum ^= 32'd1 << $urandom_range(0, 31);
			for (int i = 0; i < 4; i++) bytes_out.push_back(sum[8*i +: 8]);
			n = (rq.cut != 0) ? int'(rq.cut) : bytes_out.size();
			for (int i = 0; i < n; i++) begin
				offer(1'b0, bytes_out[i], (i == 0) ? rq.exp_off : 63'(rnd64()), rq.pin,
					rq.verdict);
			end
			if (rq.cut != 0) offer(1'b1, 8'($urandom), 63'(rnd64()), rq.pin, rq.verdict);
		end
		endcase
	endtask

	task automatic random_record();
		rec_t rq;
		logic [31:0] lim;
		int pick;
		rq = '0;
		rq.op = OP_REC;
		rq.magic = cfg_magic;
		rq.exp_off = 63'(rnd64());
		rq.off = {1'b0, rq.exp_off};
		lim = (cfg_max_len < 40) ? cfg_max_len : 32'd40;
		if (lim > 12 && $urandom_range(0, 3) != 0) lim = 12;
		rq.len = 64'($urandom_range(0, lim));
		rq.npay = 8'(rq.len);
		pick = $urandom_range(0, 15);
		case (pick)
		0: rq.magic ^= 32'd1 << $urandom_range(0, 31);
		1: rq.off ^= 64'd1 << $urandom_range(0, 63);
		2: begin
			if (cfg_max_len != '1 && $urandom_range(0, 1)) rq.len = 64'(cfg_max_len) + 1;
			else rq.len = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
			rq.npay = '0;
		end
		3: rq.bad_crc = 1'b1;
		4: rq.cut = 8'($urandom_range(1, 23 + rq.npay));
		default: ;
		endcase
		send_record(rq);
		if (pick <= 3) begin
			repeat ($urandom_range(0, 3)) offer(1'b0, 8'($urandom), 63'(rnd64()), 1'b0, '0);
			offer(1'b1, 8'($urandom), 63'(rnd64()), 1'b0, '0);
		end else if (pick > 4 && $urandom_range(0, 7) == 0) begin
			offer(1'b1, 8'($urandom), 63'(rnd64()), 1'b0, '0);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		REG_MAGIC: cfg_magic = val[31:0];
		REG_MAX_LEN: cfg_max_len = val[31:0];
		REG_START: begin
			cfg_start = val[POS_W-1:0];
			pos_now = cfg_start;
		end
		default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic settle();
		while (results_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (rx_burst > 0) rx_burst--;
		else if (rx_idle_on && $urandom_range(0, 11) == 0) rx_burst = $urandom_range(1, 18);
		out_stall <= hold_active || rx_burst > 0;
	end

	// long output hold so the result queue fills and the input backs up
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				$error("result_kind: none due, got %0d", result_kind);
				n_fail++;
			end else begin
				want = results_due.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
					n_fail++;
				end
				if (payload_byte !== want.pbyte) begin
					$error("payload_byte: expected %0h, got %0h", want.pbyte, payload_byte);
					n_fail++;
				end
				if (end_position !== want.pos) begin
					$error("end_position: expected %0h, got %0h", want.pos, end_position);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		cfg_magic = '0;
		cfg_max_len = '1;
		cfg_start = '0;
		rearm_record();
		off_latched = '0;
		pos_now = '0;
		halted_now = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_plan[i]) send_record(directed_plan[i]);
		in_valid <= 1'b0;

		phase_cfg[0] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h0};
		phase_cfg[1] = '{$urandom, 32'd0, 48'hFFFF_FFFF_FFF0};
		phase_cfg[2] = '{$urandom, 32'd40, 48'(rnd64())};
		phase_cfg[3] = '{32'h0, 32'd5, 48'hFFFF_FFFF_FFFF};
		phase_cfg[4] = '{$urandom, 32'hFFFF_FFFF, 48'(rnd64())};

		for (int p = 0; p < 5; p++) begin
			settle();
			write_reg(REG_MAGIC, 64'(phase_cfg[p].magic));
			write_reg(REG_MAX_LEN, 64'(phase_cfg[p].max_len));
			write_reg(REG_START, 64'(phase_cfg[p].start_pos));
			if (p == 1) write_reg(REG_NONE, rnd64());
			tx_idle_on = (p == 0 || p == 1 || p == 3);
			rx_idle_on = (p == 0 || p == 3);
			if (p == 2) hold_go = 1'b1;
			live_words = 0;
			while (live_words < PHASE_WORDS) random_record();
			offer(1'b1, 8'($urandom), 63'(rnd64()), 1'b0, '0);
			in_valid <= 1'b0;
		end

		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
